// ===== rtl/core/dpgc_pkg.sv =====
// Shared constants, types and codes of the pixel pedestal and gain correction block.
package dpgc_pkg;

   // Detector geometry.
   localparam int ROW_PIXELS   = 1024;
   localparam int ROW_COUNT    = 512;
   localparam int MODULE_COUNT = 2;
   localparam int MOD_PIXELS   = ROW_PIXELS * ROW_COUNT;
   localparam int STORE_DEPTH  = MOD_PIXELS * MODULE_COUNT;
   localparam int PIX_W        = $clog2(MOD_PIXELS);
   localparam int COL_W        = $clog2(ROW_PIXELS);
   localparam int ROW_W        = PIX_W - COL_W;
   localparam int SLOT_W       = $clog2(STORE_DEPTH);

   // Multi-pixel gaps in the output image.
   localparam int GROUP_SHIFT  = 8;
   localparam int GROUP_W      = COL_W - GROUP_SHIFT;
   localparam int SPLIT_ROW    = 255;
   localparam int SPLIT_GAP    = 2 * 1030;

   // Field widths.
   localparam int RAW_W        = 16;
   localparam int SAMPLE_W     = 14;
   localparam int CAL_W        = 24;
   localparam int FRAC_W       = 10;
   localparam int OUT_W        = 21;
   localparam int VALUE_W      = 16;

   // Pedestal tracking: new = (99 * old + sample) / 100, division by reciprocal.
   localparam int NUM_W        = 31;
   localparam int PED_KEEP     = 99;
   localparam int RECIP_W      = 32;
   localparam int RECIP_SHIFT  = 38;
   localparam int RPROD_W      = NUM_W + RECIP_W;

   // Correction product and rounding.
   localparam int PROD_W       = 2 * CAL_W;
   localparam int ROUND_SHIFT  = 26;
   localparam int MAG_W        = PROD_W + 1 - ROUND_SHIFT;

   // Register port.
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_IDX_W    = CSR_ADDR_W - 2;

   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [PIX_W-1:0]      pix_type;
   typedef logic [ROW_W-1:0]      row_type;
   typedef logic [OUT_W-1:0]      addr_type;
   typedef logic [CAL_W-1:0]      word_type;
   typedef logic [CAL_W:0]        wide_word_type;
   typedef logic [SAMPLE_W-1:0]   sample_type;
   typedef logic [VALUE_W-1:0]    value_type;
   typedef logic [NUM_W-1:0]      num_type;
   typedef logic [RECIP_W-1:0]    recip_type;
   typedef logic [RPROD_W-1:0]    rprod_type;
   typedef logic [PROD_W-1:0]     prod_type;
   typedef logic [PROD_W:0]       rsum_type;
   typedef logic [MAG_W-1:0]      mag_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam recip_type  RECIP_100  = recip_type'(64'd2748779070);
   localparam rsum_type   ROUND_HALF = rsum_type'(1) << (ROUND_SHIFT - 1);
   localparam mag_type    POS_LIMIT  = mag_type'(32767);
   localparam mag_type    NEG_LIMIT  = mag_type'(32768);
   localparam value_type  VALUE_MAX  = value_type'(32767);
   localparam value_type  VALUE_MIN  = value_type'(32768);
   localparam sample_type ADC_ZERO   = sample_type'(0);
   localparam sample_type ADC_FULL   = sample_type'(14'h3fff);

   // Operation and gain codes.
   localparam logic       FUNC_LOAD    = 1'b0;
   localparam logic       FUNC_CONVERT = 1'b1;
   localparam logic [1:0] GAIN_G0      = 2'd0;
   localparam logic [1:0] GAIN_G1      = 2'd1;
   localparam logic [1:0] GAIN_NONE    = 2'd2;
   localparam logic [1:0] GAIN_G2      = 2'd3;

   // Register indexes.
   localparam csr_idx_type REG_MODULE = csr_idx_type'(0);

   // One pixel's calibration, one memory word.
   typedef struct packed {
      word_type gain_g0;
      word_type gain_g1;
      word_type gain_g2;
      word_type pede_g0;
      word_type pede_g1;
      word_type pede_g2;
      word_type pede_rms;
   } cal_type;

   localparam int CAL_BITS = $bits(cal_type);

endpackage

// ===== rtl/core/dpgc_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module dpgc_ram #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [2**ADDR_W];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/detector_pixel_gain_pedestal_correct.sv =====
// Top level of the per-pixel pedestal subtraction and gain correction block.
//
// The req channel carries load and convert items. A load writes the seven
// calibration words of one pixel and gives no result. A convert gives one
// result on the rsp channel (output address and corrected value), except for
// gain code 10, which is taken and dropped. module_number is to be written
// through the csr port only while idle, which the block does not enforce.
//
// Throughput is one item per clock while req_stall is low. A result passes
// through stage registers one to six and the output register to rsp, and it
// transfers on an edge where rsp_stall is low. Calibration lives in one wide
// memory word per pixel; loads and G0 pedestal write-backs go to it from
// stage four. A convert of a pixel that has such a write still in stages one
// to four waits, so back-to-back converts of one pixel in G0 wait on each write.
//
// A stalled rsp transfer holds its payload; stages fill bubbles behind it, and
// req_stall rises when stage one cannot move or a convert waits for a write.
// Reset clears the pipeline valid bits and module_number. The memory is not
// cleared: a pixel reads undefined calibration until it has been loaded.
module detector_pixel_gain_pedestal_correct (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_func,
   input  logic [18:0]                          req_pixel_index,
   input  logic [15:0]                          req_raw_word,
   input  logic [23:0]                          req_gain_g0,
   input  logic [23:0]                          req_gain_g1,
   input  logic [23:0]                          req_gain_g2,
   input  logic [23:0]                          req_pede_g0,
   input  logic [23:0]                          req_pede_g1,
   input  logic [23:0]                          req_pede_g2,
   input  logic [23:0]                          req_pede_rms,
   // Response channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [20:0]                          rsp_out_address,
   output logic signed [15:0]                   rsp_pixel_value,
   // Register port.
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dpgc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [dpgc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [dpgc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   typedef struct packed {
      logic                 load;
      logic [1:0]           code;
      dpgc_pkg::sample_type sample;
      dpgc_pkg::slot_type   slot;
      dpgc_pkg::addr_type   addr;
      dpgc_pkg::cal_type    cal;
   } s1_type;

   typedef struct packed {
      logic                 load;
      logic [1:0]           code;
      dpgc_pkg::sample_type sample;
      dpgc_pkg::slot_type   slot;
      dpgc_pkg::addr_type   addr;
      dpgc_pkg::cal_type    cal;
      logic                 upd;
   } s2_type;

   typedef struct packed {
      logic                 load;
      logic [1:0]           code;
      dpgc_pkg::sample_type sample;
      dpgc_pkg::slot_type   slot;
      dpgc_pkg::addr_type   addr;
      dpgc_pkg::cal_type    cal;
      logic                 upd;
      dpgc_pkg::num_type    num;
   } s3_type;

   typedef struct packed {
      logic                 load;
      logic [1:0]           code;
      dpgc_pkg::sample_type sample;
      dpgc_pkg::slot_type   slot;
      dpgc_pkg::addr_type   addr;
      dpgc_pkg::cal_type    cal;
      logic                 upd;
      dpgc_pkg::word_type   quot;
   } s4_type;

   typedef struct packed {
      logic [1:0]           code;
      dpgc_pkg::sample_type sample;
      dpgc_pkg::addr_type   addr;
      logic                 neg;
      dpgc_pkg::word_type   mag;
      dpgc_pkg::word_type   gain;
   } s5_type;

   typedef struct packed {
      logic [1:0]           code;
      dpgc_pkg::sample_type sample;
      dpgc_pkg::addr_type   addr;
      logic                 neg;
      dpgc_pkg::prod_type   prod;
   } s6_type;

   // Configuration.
   logic                        module_ff, module_in;
   logic                        csr_wr;
   dpgc_pkg::csr_idx_type       csr_idx;

   // Request decode.
   logic                        req_accept;
   logic [1:0]                  req_code;
   dpgc_pkg::pix_type           req_pix;
   dpgc_pkg::row_type           req_row;
   logic [dpgc_pkg::GROUP_W-1:0] req_group;
   dpgc_pkg::slot_type          req_slot;
   dpgc_pkg::addr_type          req_place;
   dpgc_pkg::addr_type          req_addr;
   logic                        hazard;

   // Pipeline.
   logic   s1_valid_ff, s1_valid_in, s1_rdy;
   logic   s2_valid_ff, s2_valid_in, s2_rdy;
   logic   s3_valid_ff, s3_valid_in, s3_rdy;
   logic   s4_valid_ff, s4_valid_in, s4_rdy;
   logic   s5_valid_ff, s5_valid_in, s5_rdy;
   logic   s6_valid_ff, s6_valid_in, s6_rdy;
   logic   out_rdy;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;

   // Memory.
   logic [dpgc_pkg::CAL_BITS-1:0] ram_q;
   logic                          ram_wr_en;
   dpgc_pkg::cal_type             wr_cal;

   // Stage datapath.
   dpgc_pkg::cal_type             cal1;
   dpgc_pkg::word_type            sq1, dist1;
   dpgc_pkg::word_type            sq2;
   dpgc_pkg::rprod_type           rprod3;
   dpgc_pkg::word_type            sq4, ped_g0_4, ped4, gain4;
   dpgc_pkg::prod_type            prod5;
   dpgc_pkg::rsum_type            rsum6;
   dpgc_pkg::mag_type             r6;
   dpgc_pkg::value_type           value6;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   dpgc_pkg::addr_type            out_address_ff, out_address_in;
   dpgc_pkg::value_type           pixel_value_ff, pixel_value_in;

   // ---------------------------------------------------------------- csr

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[dpgc_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign module_in  = (csr_wr && csr_idx == dpgc_pkg::REG_MODULE) ? csr_pwdata[0] : module_ff;
   assign csr_prdata = (csr_idx == dpgc_pkg::REG_MODULE) ?
                       dpgc_pkg::csr_data_type'(module_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         module_ff <= 1'b0;
      end else begin
         module_ff <= module_in;
      end
   end

   // ------------------------------------------------------------ request

   assign req_code  = req_raw_word[dpgc_pkg::RAW_W-1:dpgc_pkg::SAMPLE_W];
   // The store depth per module is a power of two, so the wrap is a truncation.
   assign req_pix   = req_pixel_index[dpgc_pkg::PIX_W-1:0];
   assign req_row   = req_pix[dpgc_pkg::PIX_W-1:dpgc_pkg::COL_W];
   assign req_group = req_pix[dpgc_pkg::COL_W-1:dpgc_pkg::GROUP_SHIFT];
   assign req_slot  = module_ff ?
                      dpgc_pkg::slot_type'(dpgc_pkg::MOD_PIXELS) + dpgc_pkg::slot_type'(req_pix) :
                      dpgc_pkg::slot_type'(req_pix);
   assign req_place = dpgc_pkg::addr_type'(req_pix)
                    + ((req_row > dpgc_pkg::row_type'(dpgc_pkg::SPLIT_ROW)) ?
                       dpgc_pkg::addr_type'(dpgc_pkg::SPLIT_GAP) : '0)
                    + dpgc_pkg::addr_type'({req_group, 1'b0});
   assign req_addr  = req_place + (module_ff ? dpgc_pkg::addr_type'(dpgc_pkg::MOD_PIXELS) : '0);

   // A convert must not read a word that an earlier item has yet to write.
   assign hazard = (req_func == dpgc_pkg::FUNC_CONVERT) && (
        (s1_valid_ff && (s1_ff.load || s1_ff.code == dpgc_pkg::GAIN_G0) && s1_ff.slot == req_slot)
     || (s2_valid_ff && (s2_ff.load || s2_ff.code == dpgc_pkg::GAIN_G0) && s2_ff.slot == req_slot)
     || (s3_valid_ff && (s3_ff.load || s3_ff.code == dpgc_pkg::GAIN_G0) && s3_ff.slot == req_slot)
     || (s4_valid_ff && (s4_ff.load || s4_ff.code == dpgc_pkg::GAIN_G0) && s4_ff.slot == req_slot));

   assign req_stall  = !s1_rdy || hazard;
   assign req_accept = req_valid && !req_stall;

   // ------------------------------------------------------ stage readiness

   assign out_rdy = !rsp_valid_ff || !rsp_stall;
   assign s6_rdy  = !s6_valid_ff || out_rdy;
   assign s5_rdy  = !s5_valid_ff || s6_rdy;
   // A load ends in stage four with its write and never moves on.
   assign s4_rdy  = !s4_valid_ff || s4_ff.load || s5_rdy;
   assign s3_rdy  = !s3_valid_ff || s4_rdy;
   assign s2_rdy  = !s2_valid_ff || s3_rdy;
   assign s1_rdy  = !s1_valid_ff || s2_rdy;

   assign s1_valid_in  = s1_rdy ? (req_accept && (req_func == dpgc_pkg::FUNC_LOAD
                                   || req_code != dpgc_pkg::GAIN_NONE)) : s1_valid_ff;
   assign s2_valid_in  = s2_rdy ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = s3_rdy ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in  = s4_rdy ? s3_valid_ff : s4_valid_ff;
   assign s5_valid_in  = s5_rdy ? (s4_valid_ff && !s4_ff.load) : s5_valid_ff;
   assign s6_valid_in  = s6_rdy ? s5_valid_ff : s6_valid_ff;
   assign rsp_valid_in = out_rdy ? s6_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         s5_valid_ff  <= s5_valid_in;
         s6_valid_ff  <= s6_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------- memory

   // Reading whenever stage one can take a new item keeps the read data
   // steady while stage one holds.
   dpgc_ram #(
      .WIDTH  (dpgc_pkg::CAL_BITS),
      .ADDR_W (dpgc_pkg::SLOT_W)
   ) u_cal_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s4_ff.slot),
      .wr_data (wr_cal),
      .rd_en   (s1_rdy),
      .rd_addr (req_slot),
      .rd_data (ram_q)
   );

   // ------------------------------------------- stage 1: read data, G0 test

   always_comb begin
      s1_in = s1_ff;
      if (s1_rdy) begin
         s1_in.load           = (req_func == dpgc_pkg::FUNC_LOAD);
         s1_in.code           = req_code;
         s1_in.sample         = req_raw_word[dpgc_pkg::SAMPLE_W-1:0];
         s1_in.slot           = req_slot;
         s1_in.addr           = req_addr;
         s1_in.cal.gain_g0    = req_gain_g0;
         s1_in.cal.gain_g1    = req_gain_g1;
         s1_in.cal.gain_g2    = req_gain_g2;
         s1_in.cal.pede_g0    = req_pede_g0;
         s1_in.cal.pede_g1    = req_pede_g1;
         s1_in.cal.pede_g2    = req_pede_g2;
         s1_in.cal.pede_rms   = req_pede_rms;
      end
   end

   assign cal1  = s1_ff.load ? s1_ff.cal : dpgc_pkg::cal_type'(ram_q);
   assign sq1   = {s1_ff.sample, {dpgc_pkg::FRAC_W{1'b0}}};
   assign dist1 = (cal1.pede_g0 > sq1) ? (cal1.pede_g0 - sq1) : (sq1 - cal1.pede_g0);

   always_comb begin
      s2_in = s2_ff;
      if (s2_rdy) begin
         s2_in.load   = s1_ff.load;
         s2_in.code   = s1_ff.code;
         s2_in.sample = s1_ff.sample;
         s2_in.slot   = s1_ff.slot;
         s2_in.addr   = s1_ff.addr;
         s2_in.cal    = cal1;
         // The pedestal tracks only samples that lie strictly within twice the RMS.
         s2_in.upd    = !s1_ff.load && (s1_ff.code == dpgc_pkg::GAIN_G0)
                        && (dpgc_pkg::wide_word_type'(dist1) < {cal1.pede_rms, 1'b0});
      end
   end

   // ---------------------------------------- stage 2: 99 * pedestal + sample

   assign sq2 = {s2_ff.sample, {dpgc_pkg::FRAC_W{1'b0}}};

   always_comb begin
      s3_in = s3_ff;
      if (s3_rdy) begin
         s3_in.load   = s2_ff.load;
         s3_in.code   = s2_ff.code;
         s3_in.sample = s2_ff.sample;
         s3_in.slot   = s2_ff.slot;
         s3_in.addr   = s2_ff.addr;
         s3_in.cal    = s2_ff.cal;
         s3_in.upd    = s2_ff.upd;
         s3_in.num    = dpgc_pkg::num_type'(s2_ff.cal.pede_g0)
                        * dpgc_pkg::num_type'(dpgc_pkg::PED_KEEP)
                        + dpgc_pkg::num_type'(sq2);
      end
   end

   // ------------------------------------------ stage 3: divide by hundred

   // The reciprocal is exact for every numerator below 2^31.
   assign rprod3 = dpgc_pkg::rprod_type'(s3_ff.num) * dpgc_pkg::rprod_type'(dpgc_pkg::RECIP_100);

   always_comb begin
      s4_in = s4_ff;
      if (s4_rdy) begin
         s4_in.load   = s3_ff.load;
         s4_in.code   = s3_ff.code;
         s4_in.sample = s3_ff.sample;
         s4_in.slot   = s3_ff.slot;
         s4_in.addr   = s3_ff.addr;
         s4_in.cal    = s3_ff.cal;
         s4_in.upd    = s3_ff.upd;
         s4_in.quot   = rprod3[dpgc_pkg::RECIP_SHIFT +: dpgc_pkg::CAL_W];
      end
   end

   // ------------------------- stage 4: write-back, select, signed difference

   assign ped_g0_4  = s4_ff.upd ? s4_ff.quot : s4_ff.cal.pede_g0;
   assign ram_wr_en = s4_valid_ff && s4_rdy
                      && (s4_ff.load || s4_ff.code == dpgc_pkg::GAIN_G0);

   always_comb begin
      wr_cal         = s4_ff.cal;
      wr_cal.pede_g0 = ped_g0_4;
   end

   always_comb begin
      case (s4_ff.code)
         dpgc_pkg::GAIN_G0: begin
            ped4  = ped_g0_4;
            gain4 = s4_ff.cal.gain_g0;
         end
         dpgc_pkg::GAIN_G1: begin
            ped4  = s4_ff.cal.pede_g1;
            gain4 = s4_ff.cal.gain_g1;
         end
         default: begin
            ped4  = s4_ff.cal.pede_g2;
            gain4 = s4_ff.cal.gain_g2;
         end
      endcase
   end

   assign sq4 = {s4_ff.sample, {dpgc_pkg::FRAC_W{1'b0}}};

   always_comb begin
      s5_in = s5_ff;
      if (s5_rdy) begin
         s5_in.code   = s4_ff.code;
         s5_in.sample = s4_ff.sample;
         s5_in.addr   = s4_ff.addr;
         s5_in.neg    = ped4 > sq4;
         s5_in.mag    = (ped4 > sq4) ? (ped4 - sq4) : (sq4 - ped4);
         s5_in.gain   = gain4;
      end
   end

   // --------------------------------------------------- stage 5: multiply

   assign prod5 = dpgc_pkg::prod_type'(s5_ff.mag) * dpgc_pkg::prod_type'(s5_ff.gain);

   always_comb begin
      s6_in = s6_ff;
      if (s6_rdy) begin
         s6_in.code   = s5_ff.code;
         s6_in.sample = s5_ff.sample;
         s6_in.addr   = s5_ff.addr;
         s6_in.neg    = s5_ff.neg;
         s6_in.prod   = prod5;
      end
   end

   // ------------------------------------------ stage 6: round and saturate

   assign rsum6 = dpgc_pkg::rsum_type'(s6_ff.prod) + dpgc_pkg::ROUND_HALF;
   assign r6    = rsum6[dpgc_pkg::PROD_W:dpgc_pkg::ROUND_SHIFT];

   always_comb begin
      if (s6_ff.code == dpgc_pkg::GAIN_G2
          && (s6_ff.sample == dpgc_pkg::ADC_ZERO || s6_ff.sample == dpgc_pkg::ADC_FULL)) begin
         // A bad or saturated G2 sample reads as full scale.
         value6 = dpgc_pkg::VALUE_MAX;
      end else if (s6_ff.neg) begin
         value6 = (r6 > dpgc_pkg::NEG_LIMIT) ? dpgc_pkg::VALUE_MIN
                                              : -r6[dpgc_pkg::VALUE_W-1:0];
      end else begin
         value6 = (r6 > dpgc_pkg::POS_LIMIT) ? dpgc_pkg::VALUE_MAX
                                              : r6[dpgc_pkg::VALUE_W-1:0];
      end
   end

   assign out_address_in = out_rdy ? s6_ff.addr : out_address_ff;
   assign pixel_value_in = out_rdy ? value6     : pixel_value_ff;

   always_ff @(posedge clock) begin
      s1_ff          <= s1_in;
      s2_ff          <= s2_in;
      s3_ff          <= s3_in;
      s4_ff          <= s4_in;
      s5_ff          <= s5_in;
      s6_ff          <= s6_in;
      out_address_ff <= out_address_in;
      pixel_value_ff <= pixel_value_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_address = out_address_ff;
   assign rsp_pixel_value = $signed(pixel_value_ff);

endmodule

// ===== rtl/core/dpgc_checker.sv =====
// Port-level checks of the correction block, bound to its top level.
module dpgc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [20:0]                       rsp_out_address,
   input logic signed [15:0]                rsp_pixel_value,
   input logic                              csr_psel,
   input logic                              csr_penable,
   input logic                              csr_pwrite,
   input logic [dpgc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input logic [dpgc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input logic [dpgc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input logic                              csr_pready
);

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A stalled result keeps its transfer payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_address)
                                 && $stable(rsp_pixel_value))
      else $error("stalled result changed");

   // The register port never inserts wait states.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port not ready");

   // A write to module_number reads back on the next cycle.
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready
      && csr_paddr[dpgc_pkg::CSR_ADDR_W-1:2] == dpgc_pkg::REG_MODULE
      |=> csr_paddr[dpgc_pkg::CSR_ADDR_W-1:2] != dpgc_pkg::REG_MODULE
          || csr_prdata[0] == $past(csr_pwdata[0]))
      else $error("module_number readback mismatch");

endmodule

bind detector_pixel_gain_pedestal_correct dpgc_checker u_dpgc_checker (.*);
